FILE: src/tdq_pkg.sv
// Shared types and constants of the two-half teque unit.
// Depends on nothing; used by the controller, the datapath and the top level.
package tdq_pkg;

    // Element width
    localparam int unsigned DATA_W = 32;

    // Request kinds (carried in tuser of the request channel)
    localparam logic [1:0] ACT_PUSH_FRONT  = 2'd0;
    localparam logic [1:0] ACT_PUSH_BACK   = 2'd1;
    localparam logic [1:0] ACT_PUSH_MIDDLE = 2'd2;
    localparam logic [1:0] ACT_GET         = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming request
        logic exec;    // decide, issue ring reads, update starts and counts
        logic commit;  // perform ring writes and load the result register
    } t_cmd;

endpackage

FILE: src/tdq_ram.sv
// Single-port ring storage for one half of the teque, registered read data.
// Depends on tdq_pkg for the element width.
module tdq_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_addr,
    input  logic [tdq_pkg::DATA_W-1:0] i_wdata,
    output logic [tdq_pkg::DATA_W-1:0] o_rdata
);

    logic [tdq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [tdq_pkg::DATA_W-1:0] r_rdata;

    // One access per cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tdq_ctrl.sv
// Request sequencer of the teque: handshakes and the two-step request flow.
// Depends on tdq_pkg for the command struct.
module tdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output tdq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WB   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;
    logic   commit;

    // Result slot is free when empty or being drained this cycle
    assign slot_free  = !r_out_valid || i_m_tready;
    assign commit     = (r_state == S_WB) && slot_free;
    assign o_s_tready = (r_state == S_IDLE) || commit;
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (commit) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_cmd.load    = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.commit  = commit;

    // A decision step is always followed by the write-back step, where the result is committed at once or after waiting
    a_commit_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_WB))
        else $error("decision step not followed by write-back");

    // A new result never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !commit)
        else $error("result overwritten while stalled");

    // A held result stays offered until it is taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped before it was taken");

endmodule

FILE: src/tdq_dp.sv
// Datapath of the teque: request register, ring pointers and counts, two half
// rings and the result register. Depends on tdq_pkg and tdq_ram.
module tdq_dp #(
    parameter int unsigned CAPACITY = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tdq_pkg::t_cmd              i_cmd,
    input  logic [1:0]                 i_action,
    input  logic [tdq_pkg::DATA_W-1:0] i_value,
    input  logic [11:0]                i_position,
    output logic [tdq_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                 o_status,
    output logic [12:0]                o_total_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = CW + 12;
    localparam int unsigned DW = tdq_pkg::DATA_W;

    // Ring index arithmetic, one compare-subtract or wrap each
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(k);
        if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    endfunction

    // Request register
    logic [1:0]    r_act;
    logic [DW-1:0] r_val;
    logic [11:0]   r_pos;

    // Ring state
    logic [AW-1:0] r_ls, n_ls, r_rs, n_rs;
    logic [CW-1:0] r_l, n_l, r_r, n_r;

    // Write-back plan
    logic [AW-1:0] r_lw_addr, n_lw_addr, r_rw_addr, n_rw_addr;
    logic          r_lw_en, n_lw_en, r_rw_en, n_rw_en;
    logic          r_lw_mv, n_lw_mv, r_rw_mv, n_rw_mv;
    logic          r_mv_left, n_mv_left, r_byp, n_byp;
    logic          r_hit, n_hit, r_hit_left, n_hit_left;
    logic [1:0]    r_st, n_st;

    // Reads issued in the decision step
    logic          rd_l_en, rd_r_en;
    logic [AW-1:0] rd_l_addr, rd_r_addr;

    // Result register
    logic [DW-1:0] r_out_val;
    logic [1:0]    r_out_st;
    logic [12:0]   r_out_tot;

    logic [CW:0]     tot;
    logic            full;
    logic [XW-1:0]   pos_x;
    logic [CW-1:0]   l_inc, r_inc;
    logic [DW-1:0]   l_rdata, r_rdata, mv;
    logic            l_en, l_we, r_en, r_we;
    logic [AW-1:0]   l_addr, r_addr;
    logic [DW-1:0]   l_wdata, r_wdata;
    logic [CW+12:0]  tot_after;

    assign tot   = (CW+1)'(r_l) + (CW+1)'(r_r);
    assign full  = tot >= (CW+1)'(CAPACITY);
    assign pos_x = XW'(r_pos);
    assign l_inc = r_l + CW'(1);
    assign r_inc = r_r + CW'(1);

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_val <= i_value;
            r_pos <= i_position;
        end
    end

    // Decision step: new starts and counts, reads to issue, writes to plan
    always_comb begin
        n_ls = r_ls;  n_rs = r_rs;  n_l = r_l;  n_r = r_r;
        n_lw_en = 1'b0;  n_lw_addr = r_ls;  n_lw_mv = 1'b0;
        n_rw_en = 1'b0;  n_rw_addr = r_rs;  n_rw_mv = 1'b0;
        n_mv_left = 1'b0;  n_byp = 1'b0;
        n_hit = 1'b0;  n_hit_left = 1'b0;
        n_st = tdq_pkg::ST_OK;
        rd_l_en = 1'b0;  rd_l_addr = r_ls;
        rd_r_en = 1'b0;  rd_r_addr = r_rs;
        if (r_act != tdq_pkg::ACT_GET && full) begin
            n_st = tdq_pkg::ST_FULL;
        end else begin
            unique case (r_act)
                tdq_pkg::ACT_PUSH_FRONT: begin
                    n_ls      = ring_dec(r_ls);
                    n_lw_en   = 1'b1;
                    n_lw_addr = n_ls;
                    if (l_inc > r_r) begin
                        // last left element crosses to the right front
                        rd_l_en   = 1'b1;
                        rd_l_addr = ring_add(n_ls, r_l);
                        n_mv_left = 1'b1;
                        n_byp     = (r_l == '0);
                        n_rs      = ring_dec(r_rs);
                        n_rw_en   = 1'b1;
                        n_rw_addr = n_rs;
                        n_rw_mv   = 1'b1;
                        n_r       = r_inc;
                    end else begin
                        n_l = l_inc;
                    end
                end
                tdq_pkg::ACT_PUSH_BACK: begin
                    n_rw_en   = 1'b1;
                    n_rw_addr = ring_add(r_rs, r_r);
                    if (r_inc > r_l) begin
                        // first right element crosses to the left back
                        rd_r_en   = 1'b1;
                        rd_r_addr = r_rs;
                        n_byp     = (r_r == '0);
                        n_rs      = ring_inc(r_rs);
                        n_lw_en   = 1'b1;
                        n_lw_addr = ring_add(r_ls, r_l);
                        n_lw_mv   = 1'b1;
                        n_l       = l_inc;
                    end else begin
                        n_r = r_inc;
                    end
                end
                tdq_pkg::ACT_PUSH_MIDDLE: begin
                    n_rw_en = 1'b1;
                    if (r_l < r_r) begin
                        // right front moves left; the value takes its slot
                        rd_r_en   = 1'b1;
                        rd_r_addr = r_rs;
                        n_lw_en   = 1'b1;
                        n_lw_addr = ring_add(r_ls, r_l);
                        n_lw_mv   = 1'b1;
                        n_l       = l_inc;
                        n_rw_addr = r_rs;
                    end else begin
                        n_rs      = ring_dec(r_rs);
                        n_rw_addr = n_rs;
                        n_r       = r_inc;
                    end
                end
                tdq_pkg::ACT_GET: begin
                    if (pos_x >= XW'(tot)) begin
                        n_st = tdq_pkg::ST_RANGE;
                    end else if (pos_x < XW'(r_l)) begin
                        n_hit      = 1'b1;
                        n_hit_left = 1'b1;
                        rd_l_en    = 1'b1;
                        rd_l_addr  = ring_add(r_ls, CW'(pos_x));
                    end else begin
                        n_hit     = 1'b1;
                        rd_r_en   = 1'b1;
                        rd_r_addr = ring_add(r_rs, CW'(pos_x - XW'(r_l)));
                    end
                end
                default: begin
                    n_st = tdq_pkg::ST_OK;
                end
            endcase
        end
    end

    // Ring state updates at the decision step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls <= '0;
            r_rs <= '0;
            r_l  <= '0;
            r_r  <= '0;
        end else if (i_cmd.exec) begin
            r_ls <= n_ls;
            r_rs <= n_rs;
            r_l  <= n_l;
            r_r  <= n_r;
        end
    end

    // Write-back plan register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_lw_en    <= n_lw_en;
            r_lw_addr  <= n_lw_addr;
            r_lw_mv    <= n_lw_mv;
            r_rw_en    <= n_rw_en;
            r_rw_addr  <= n_rw_addr;
            r_rw_mv    <= n_rw_mv;
            r_mv_left  <= n_mv_left;
            r_byp      <= n_byp;
            r_hit      <= n_hit;
            r_hit_left <= n_hit_left;
            r_st       <= n_st;
        end
    end

    // Element that crosses the boundary
    always_comb begin
        if (r_byp) begin
            mv = r_val;
        end else if (r_mv_left) begin
            mv = l_rdata;
        end else begin
            mv = r_rdata;
        end
    end

    // Ring port muxing: reads at the decision step, writes at commit
    assign l_we    = !i_cmd.exec;
    assign r_we    = !i_cmd.exec;
    assign l_en    = i_cmd.exec ? rd_l_en : (i_cmd.commit && r_lw_en);
    assign r_en    = i_cmd.exec ? rd_r_en : (i_cmd.commit && r_rw_en);
    assign l_addr  = i_cmd.exec ? rd_l_addr : r_lw_addr;
    assign r_addr  = i_cmd.exec ? rd_r_addr : r_rw_addr;
    assign l_wdata = r_lw_mv ? mv : r_val;
    assign r_wdata = r_rw_mv ? mv : r_val;

    tdq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_left (
        .i_clk   (i_clk),
        .i_en    (l_en),
        .i_we    (l_we),
        .i_addr  (l_addr),
        .i_wdata (l_wdata),
        .o_rdata (l_rdata)
    );

    tdq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_right (
        .i_clk   (i_clk),
        .i_en    (r_en),
        .i_we    (r_we),
        .i_addr  (r_addr),
        .i_wdata (r_wdata),
        .o_rdata (r_rdata)
    );

    // Result register
    assign tot_after = (CW+13)'(r_l) + (CW+13)'(r_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_val <= r_hit ? (r_hit_left ? l_rdata : r_rdata) : '0;
            r_out_st  <= r_st;
            r_out_tot <= tot_after[12:0];
        end
    end

    assign o_read_value  = r_out_val;
    assign o_status      = r_out_st;
    assign o_total_count = r_out_tot;

    // Halves stay balanced: their sizes differ by at most one
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r == r_l) || (r_r == l_inc) || (r_l == r_inc))
        else $error("halves out of balance");

    // Counts only move at a decision step
    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_l) && $stable(r_r)))
        else $error("counts changed outside a decision step");

    // A rejected push leaves the ring state untouched
    a_full_noop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && full && r_act != tdq_pkg::ACT_GET)
            |=> ($stable(r_l) && $stable(r_r) && $stable(r_ls) && $stable(r_rs)))
        else $error("rejected push changed state");

endmodule

FILE: src/teque_two_half_deque_unit.sv
// Top level of the two-half teque unit: request and result streams.
// Depends on tdq_pkg, tdq_ctrl and tdq_dp (which holds the tdq_ram rings).
//
// A bounded teque of up to CAPACITY signed 32-bit elements taking push front,
// push back, push middle and get-at-index requests, one result per request.
// Each request runs a decision step that reads at most one ring and updates
// the ring starts and counts, then a write-back step that writes the planned
// half-ring slots and loads the result register; each half is a single-port
// ring, so the read and the writes sit in separate cycles. A new request is
// taken as the previous result commits; a stalled result holds the block in
// write-back until it is taken. No clearing pass is needed after reset.
// A push to a full block returns status 1, a get at or beyond the size
// returns status 2 with a zero value; neither changes the contents.
module teque_two_half_deque_unit #(
    parameter int unsigned CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [31:0] value, [43:32] position, [47:44] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] read_value, [44:32] total_count, [47:45] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    tdq_pkg::t_cmd               cmd;
    logic [tdq_pkg::DATA_W-1:0]  read_value;
    logic [12:0]                 total_count;

    tdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    tdq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_s_tuser),
        .i_value       (i_s_tdata[31:0]),
        .i_position    (i_s_tdata[43:32]),
        .o_read_value  (read_value),
        .o_status      (o_m_tuser),
        .o_total_count (total_count)
    );

    // Pack the result payload
    assign o_m_tdata = {3'b000, total_count, read_value};

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the two-half teque unit.
// Depends on tdq_pkg and teque_two_half_deque_unit; holds its own teque predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CAP      = 4096;
    localparam int unsigned MAX_IDLE = 6;
    localparam int unsigned MAX_LOGS = 40;

    // Expected outcome of one request
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [12:0]        total_count;
    } t_teque_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata  = '0;    // [31:0] value, [43:32] position, [47:44] zero
    logic [1:0]  i_s_tuser  = '0;    // [1:0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;          // [31:0] read_value, [44:32] total_count, [47:45] zero
    logic [1:0]  o_m_tuser;          // [1:0] status

    // Predictor state: two rings, their heads and sizes
    logic signed [31:0] left_ring  [0:CAP-1];
    logic signed [31:0] right_ring [0:CAP-1];
    logic [11:0]        left_head  = '0;
    logic [12:0]        left_size  = '0;
    logic [11:0]        right_head = '0;
    logic [12:0]        right_size = '0;

    t_teque_result pending_results[$];
    int unsigned   error_count  = 0;
    int unsigned   results_seen = 0;
    bit            no_idle      = 1'b0;

    logic [1:0] push_kinds [3] = '{tdq_pkg::ACT_PUSH_FRONT, tdq_pkg::ACT_PUSH_BACK,
                                   tdq_pkg::ACT_PUSH_MIDDLE};

    teque_two_half_deque_unit #(.CAPACITY(CAP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Idle cycles drawn per request on either side
    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [12:0] teque_total();
        return left_size + right_size;
    endfunction

    // Move the first right element to the back of the left half
    function automatic void shift_right_to_left();
        logic signed [31:0] moved;
        moved = right_ring[right_head];
        right_head = right_head + 12'd1;
        right_size = right_size - 13'd1;
        left_ring[left_head + left_size[11:0]] = moved;
        left_size = left_size + 13'd1;
    endfunction

    // Apply one request to the predictor and return what the block must answer
    function automatic t_teque_result apply_teque_request(logic [1:0] act,
                                                          logic signed [31:0] val,
                                                          logic [11:0] pos);
        t_teque_result      res;
        logic signed [31:0] moved;
        logic [12:0]        total;
        total = teque_total();
        res.read_value = '0;
        res.status     = tdq_pkg::ST_OK;
        if (act != tdq_pkg::ACT_GET && total >= CAP) begin
            res.status = tdq_pkg::ST_FULL;
        end else begin
            case (act)
                tdq_pkg::ACT_PUSH_FRONT: begin
                    left_head = left_head - 12'd1;
                    left_ring[left_head] = val;
                    left_size = left_size + 13'd1;
                    // left grew past right: its last element goes to the right front
                    if (left_size > right_size) begin
                        moved = left_ring[left_head + left_size[11:0] - 12'd1];
                        left_size = left_size - 13'd1;
                        right_head = right_head - 12'd1;
                        right_ring[right_head] = moved;
                        right_size = right_size + 13'd1;
                    end
                end
                tdq_pkg::ACT_PUSH_BACK: begin
                    right_ring[right_head + right_size[11:0]] = val;
                    right_size = right_size + 13'd1;
                    if (right_size > left_size) shift_right_to_left();
                end
                tdq_pkg::ACT_PUSH_MIDDLE: begin
                    if (left_size < right_size) shift_right_to_left();
                    right_head = right_head - 12'd1;
                    right_ring[right_head] = val;
                    right_size = right_size + 13'd1;
                end
                default: begin
                    if ({1'b0, pos} >= total)
                        res.status = tdq_pkg::ST_RANGE;
                    else if ({1'b0, pos} < left_size)
                        res.read_value = left_ring[left_head + pos];
                    else
                        res.read_value = right_ring[right_head + pos - left_size[11:0]];
                end
            endcase
        end
        res.total_count = teque_total();
        return res;
    endfunction

    // One line per mismatch, printing capped
    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= MAX_LOGS)
            $display("MISMATCH result %0d %s: expected %h got %h",
                     results_seen, field, want, got);
    endtask

    // Send one request; called at a rising edge, returns at its acceptance edge
    task automatic send_request(logic [1:0] act, logic signed [31:0] val, logic [11:0] pos);
        int unsigned   gap;
        t_teque_result res;
        gap = idle_cycles();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, pos, val};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        res = apply_teque_request(act, val, pos);
        pending_results = {pending_results, res};
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Random push of any kind; ignored position is random too
    task automatic send_random_push();
        send_request(push_kinds[$urandom_range(0, 2)], $urandom,
                     12'($urandom_range(0, CAP - 1)));
    endtask

    // Reads of an empty block, including the top index
    task automatic test_empty_reads();
        send_request(tdq_pkg::ACT_GET, $urandom, 12'd0);
        send_request(tdq_pkg::ACT_GET, $urandom, 12'hFFF);
    endtask

    // Each push kind with extreme values, then read back every index
    task automatic test_each_push_kind();
        int unsigned idx;
        logic [12:0] tot;
        send_request(tdq_pkg::ACT_PUSH_FRONT,  32'sh8000_0000, 12'hFFF);
        send_request(tdq_pkg::ACT_PUSH_BACK,   32'sh7FFF_FFFF, 12'h000);
        send_request(tdq_pkg::ACT_PUSH_MIDDLE, 32'sh0000_0000, 12'hAAA);
        send_request(tdq_pkg::ACT_PUSH_MIDDLE, -32'sd1,        12'h555);
        send_request(tdq_pkg::ACT_PUSH_FRONT,  32'sd1,         12'h000);
        send_request(tdq_pkg::ACT_PUSH_BACK,   32'shA5A5_5A5A, 12'hFFF);
        for (idx = 0; idx < teque_total(); idx++)
            send_request(tdq_pkg::ACT_GET, $urandom, idx[11:0]);
        // first index past the end
        tot = teque_total();
        send_request(tdq_pkg::ACT_GET, $urandom, tot[11:0]);
    endtask

    // Mixed pushes and reads, mostly in range, with a drain and a burst stretch
    task automatic test_random_mix(int unsigned count);
        int unsigned n;
        int unsigned pick;
        for (n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            no_idle = (n >= (count * 2) / 3) && (n < (count * 2) / 3 + 70);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_random_push();
            else if (teque_total() == 0 || pick >= 92)
                send_request(tdq_pkg::ACT_GET, $urandom, 12'($urandom_range(0, CAP - 1)));
            else
                send_request(tdq_pkg::ACT_GET, $urandom,
                             12'($urandom_range(0, teque_total() - 1)));
        end
        no_idle = 1'b0;
    endtask

    // Reads at the ends of the sequence and across the half boundary, then one push of each kind and random reads
    task automatic test_index_edges();
        int unsigned k;
        logic [12:0] tot;
        drain_results();
        tot = teque_total();
        send_request(tdq_pkg::ACT_GET, $urandom, 12'd0);
        send_request(tdq_pkg::ACT_GET, $urandom, tot[11:0] - 12'd1);
        send_request(tdq_pkg::ACT_GET, $urandom, tot[11:0]);
        send_request(tdq_pkg::ACT_GET, $urandom, left_size[11:0] - 12'd1);
        send_request(tdq_pkg::ACT_GET, $urandom, left_size[11:0]);
        send_request(tdq_pkg::ACT_GET, $urandom, 12'hFFF);
        for (k = 0; k < 3; k++)
            send_request(push_kinds[k], $urandom, 12'($urandom_range(0, CAP - 1)));
        for (k = 0; k < 20; k++)
            send_request(tdq_pkg::ACT_GET, $urandom, 12'($urandom_range(0, CAP - 1)));
    endtask

    // Result side: random stalls, compare each accepted result with the oldest prediction
    initial begin : result_checker
        t_teque_result want;
        int unsigned   stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[31:0] !== want.read_value)
                    report_mismatch("read_value", want.read_value, o_m_tdata[31:0]);
                if (o_m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_m_tuser));
                if (o_m_tdata[44:32] !== want.total_count)
                    report_mismatch("total_count", 32'(want.total_count),
                                    32'(o_m_tdata[44:32]));
            end
        end
    end

    // Main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_reads();
        test_each_push_kind();
        drain_results();
        test_random_mix(650);
        test_index_edges();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/tdq_pkg.sv
src/tdq_ram.sv
src/tdq_ctrl.sv
src/tdq_dp.sv
src/teque_two_half_deque_unit.sv
sim/tb_top.sv
